// ===== rtl/rgbppe_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbppe_pkg: shared types and constants of the RGB pixel pulse encoder
//
// Channel payload structs, function and register codes, store dimensions.
// ----------------------------------------------------------------------------
package rgbppe_pkg;

   // Store dimensions
   localparam int MAX_LEDS   = 256;
   localparam int PIXEL_BITS = 24;
   localparam int LED_AW     = $clog2(MAX_LEDS);
   localparam int COUNT_W    = LED_AW + 1;
   localparam int TICK_W     = 15;
   localparam int SYM_CNT_W  = 5;

   // Configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_CLEAR = 2'd1,
      FUNC_EMIT  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      REG_CHAIN_LEN    = 3'd0,
      REG_ZERO_FIRST   = 3'd1,
      REG_ZERO_SECOND  = 3'd2,
      REG_ONE_FIRST    = 3'd3,
      REG_ONE_SECOND   = 3'd4,
      REG_LATCH_FIRST  = 3'd5,
      REG_LATCH_SECOND = 3'd6,
      REG_PHASE_LEVELS = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_ZERO  = 2'd0,
      KIND_ONE   = 2'd1,
      KIND_LATCH = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic              first_level;
      logic [TICK_W-1:0] first_ticks;
      logic              second_level;
      logic [TICK_W-1:0] second_ticks;
      logic              last;
   } rsp_type;

endpackage

// ===== rtl/rgb_pixel_pulse_encoder_core.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_pulse_encoder_core: pixel store and LED pulse symbol encoder
//
// Holds one 24-bit color per LED in a synchronous RAM and turns a stored
// pixel into pulse symbols (level/tick pairs) for a serial RGB LED chain.
// ----------------------------------------------------------------------------
// A write, or a command that is ignored, leaves the block idle. An emit
// fetches the pixel (RAM read, then load of the shift register) and then
// gives one symbol transfer per cycle while the result side keeps up: 24
// symbols, 25 for the last LED in use. A clear walks the pixel RAM one entry
// a cycle, one entry per LED in use (at most MAX_LEDS), and takes no item
// meanwhile. Configuration writes are taken any time and must only happen
// while the block is idle.
module rgb_pixel_pulse_encoder_core
   import rgbppe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CLEAR = 4'b0010,
      ST_READ  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   localparam logic [COUNT_W-1:0]   MAX_LEDS_C = COUNT_W'(MAX_LEDS);
   localparam logic [SYM_CNT_W-1:0] LAST_BIT   = SYM_CNT_W'(PIXEL_BITS - 1);
   localparam logic [SYM_CNT_W-1:0] LATCH_SYM  = SYM_CNT_W'(PIXEL_BITS);

   // configuration registers
   logic [COUNT_W-1:0] chain_len_ff;
   logic [TICK_W-1:0]  zero_first_ff, zero_second_ff;
   logic [TICK_W-1:0]  one_first_ff, one_second_ff;
   logic [TICK_W-1:0]  latch_first_ff, latch_second_ff;
   logic [5:0]         phase_levels_ff;

   // control state
   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        clr_ff, clr_in;
   logic [SYM_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                      known_ff, known_in;
   logic                      tail_ff, tail_in;
   logic [PIXEL_BITS-1:0]     px_ff, px_in;
   logic [MAX_LEDS-1:0]       written_ff, written_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   // pixel RAM
   logic [PIXEL_BITS-1:0] pix_mem [MAX_LEDS];
   logic [PIXEL_BITS-1:0] rd_data_ff;
   logic                  mem_we;
   logic [LED_AW-1:0]     mem_waddr;
   logic [PIXEL_BITS-1:0] mem_wdata;

   logic               cfg_wr;
   logic [2:0]         cfg_idx;
   logic [COUNT_W-1:0] leds_in_use;
   logic               req_xfer;
   logic               rsp_xfer;
   logic               out_free;
   logic               ix_ok;
   logic               sym_load;
   kind_type           sym_kind;

   // ------------------------------------------------------------------
   // configuration port
   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[CSR_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_len_ff    <= '0;
         zero_first_ff   <= '0;
         zero_second_ff  <= '0;
         one_first_ff    <= '0;
         one_second_ff   <= '0;
         latch_first_ff  <= '0;
         latch_second_ff <= '0;
         phase_levels_ff <= '0;
      end else if (cfg_wr) begin
         unique case (reg_index_type'(cfg_idx))
            REG_CHAIN_LEN:    chain_len_ff    <= pwdata[COUNT_W-1:0];
            REG_ZERO_FIRST:   zero_first_ff   <= pwdata[TICK_W-1:0];
            REG_ZERO_SECOND:  zero_second_ff  <= pwdata[TICK_W-1:0];
            REG_ONE_FIRST:    one_first_ff    <= pwdata[TICK_W-1:0];
            REG_ONE_SECOND:   one_second_ff   <= pwdata[TICK_W-1:0];
            REG_LATCH_FIRST:  latch_first_ff  <= pwdata[TICK_W-1:0];
            REG_LATCH_SECOND: latch_second_ff <= pwdata[TICK_W-1:0];
            REG_PHASE_LEVELS: phase_levels_ff <= pwdata[5:0];
            default:          ;
         endcase
      end
   end

   // register readback
   always_comb begin
      prdata = '0;
      unique case (reg_index_type'(cfg_idx))
         REG_CHAIN_LEN:    prdata = CSR_DW'(chain_len_ff);
         REG_ZERO_FIRST:   prdata = CSR_DW'(zero_first_ff);
         REG_ZERO_SECOND:  prdata = CSR_DW'(zero_second_ff);
         REG_ONE_FIRST:    prdata = CSR_DW'(one_first_ff);
         REG_ONE_SECOND:   prdata = CSR_DW'(one_second_ff);
         REG_LATCH_FIRST:  prdata = CSR_DW'(latch_first_ff);
         REG_LATCH_SECOND: prdata = CSR_DW'(latch_second_ff);
         REG_PHASE_LEVELS: prdata = CSR_DW'(phase_levels_ff);
         default:          prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // handshakes
   assign leds_in_use = (chain_len_ff > MAX_LEDS_C) ? MAX_LEDS_C : chain_len_ff;
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_xfer    = req_valid && !req_stall;
   assign rsp_xfer    = rsp_valid_ff && !rsp_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign ix_ok       = (COUNT_W'(req_data.pixel_index) < leds_in_use);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   // symbol kind for the current position
   always_comb begin
      if (cnt_ff == LATCH_SYM || !known_ff) begin
         sym_kind = KIND_LATCH;
      end else if (px_ff[PIXEL_BITS-1]) begin
         sym_kind = KIND_ONE;
      end else begin
         sym_kind = KIND_ZERO;
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      known_in     = known_ff;
      tail_in      = tail_ff;
      px_in        = px_ff;
      written_in   = written_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = req_data.pixel_index[LED_AW-1:0];
      mem_wdata    = {req_data.green, req_data.red, req_data.blue};
      sym_load     = 1'b0;

      // the result register drains independently of the sequencer
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_data.func)
                  FUNC_WRITE: begin
                     if (ix_ok) begin
                        mem_we = 1'b1;
                        written_in[req_data.pixel_index[LED_AW-1:0]] = 1'b1;
                     end
                  end
                  FUNC_CLEAR: begin
                     clr_in = '0;
                     if (leds_in_use != '0) begin
                        state_in = ST_CLEAR;
                     end
                  end
                  FUNC_EMIT: begin
                     if (ix_ok) begin
                        known_in = written_ff[req_data.pixel_index[LED_AW-1:0]];
                        tail_in  = (COUNT_W'(req_data.pixel_index) + COUNT_W'(1)
                                    == leds_in_use);
                        cnt_in   = '0;
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            // one RAM entry per cycle
            mem_we    = 1'b1;
            mem_waddr = clr_ff[LED_AW-1:0];
            mem_wdata = '0;
            written_in[clr_ff[LED_AW-1:0]] = 1'b1;
            clr_in    = clr_ff + COUNT_W'(1);
            if (clr_ff + COUNT_W'(1) == leds_in_use) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            px_in    = rd_data_ff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               sym_load                 = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_data_in.first_level  = phase_levels_ff[2*sym_kind];
               rsp_data_in.second_level = phase_levels_ff[2*sym_kind+1];
               unique case (sym_kind)
                  KIND_ZERO: begin
                     rsp_data_in.first_ticks  = zero_first_ff;
                     rsp_data_in.second_ticks = zero_second_ff;
                  end
                  KIND_ONE: begin
                     rsp_data_in.first_ticks  = one_first_ff;
                     rsp_data_in.second_ticks = one_second_ff;
                  end
                  default: begin
                     rsp_data_in.first_ticks  = latch_first_ff;
                     rsp_data_in.second_ticks = latch_second_ff;
                  end
               endcase
               rsp_data_in.last = (cnt_ff == LAST_BIT && !tail_ff) ||
                                  (cnt_ff == LATCH_SYM);
               px_in  = {px_ff[PIXEL_BITS-2:0], 1'b0};
               cnt_in = cnt_ff + SYM_CNT_W'(1);
               if (rsp_data_in.last) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      known_ff    <= known_in;
      tail_ff     <= tail_in;
      px_ff       <= px_in;
      rsp_data_ff <= rsp_data_in;
   end

   // pixel RAM, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pix_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= pix_mem[req_data.pixel_index[LED_AW-1:0]];
   end

`ifndef SYNTHESIS
   // the RAM is only written while idle or sweeping
   a_we_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE || state_ff == ST_CLEAR))
      else $error("pixel RAM written during an emit");

   // sweep pointer stays inside the LEDs in use
   a_clr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (clr_ff < leds_in_use))
      else $error("clear pointer beyond led count");

   // symbol counter never passes the latch symbol
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LATCH_SYM)
      else $error("symbol counter out of range");

   // loading the final symbol returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (sym_load && rsp_data_in.last) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("emit did not finish after its last symbol");

   // a latch symbol only follows the last LED in use
   a_latch_tail: assert property (@(posedge clock) disable iff (reset)
      (sym_load && cnt_ff == LATCH_SYM) |-> tail_ff)
      else $error("trailing reset pulse on an LED that is not the last");
`endif

endmodule

// ===== tb/rgb_pixel_pulse_encoder_core_test.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_pulse_encoder_core_test: self-checking bench of the pulse encoder
//
// Drives pixel writes, clears and emits through the request channel. The
// registers are programmed over the APB port between phases. A shadow copy of
// the pixel store and registers predicts every pulse symbol, and each symbol
// transfer is compared field by field in arrival order. Phases vary the chain
// length, tick values, line levels, sender idling and receiver stalls. One
// phase also holds the receiver off long enough to back up the request side.
// ----------------------------------------------------------------------------
module rgb_pixel_pulse_encoder_core_test;
   import rgbppe_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 320;   // longer than a clear of the whole chain
   localparam int HOLD_CYCLES   = 400;
   localparam int PRINT_LIMIT   = 50;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [CSR_AW-1:0] paddr     = '0;
   logic [CSR_DW-1:0] pwdata    = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   // shadow registers and pixel store
   logic [COUNT_W-1:0] chain_len_q    = '0;
   logic [TICK_W-1:0]  zero_first_q   = '0;
   logic [TICK_W-1:0]  zero_second_q  = '0;
   logic [TICK_W-1:0]  one_first_q    = '0;
   logic [TICK_W-1:0]  one_second_q   = '0;
   logic [TICK_W-1:0]  latch_first_q  = '0;
   logic [TICK_W-1:0]  latch_second_q = '0;
   logic [5:0]         levels_q       = '0;
   logic [PIXEL_BITS-1:0] pixel_q [MAX_LEDS];
   bit                 written_q [MAX_LEDS];

   rsp_type symbol_queue [$];
   int error_count        = 0;
   int cycle_count        = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_request       = 1'b0;
   bit hold_served        = 1'b0;
   int hold_left          = 0;

   always #5 clock = ~clock;

   rgb_pixel_pulse_encoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
   endtask

   function automatic int leds_in_use();
      return (chain_len_q > MAX_LEDS) ? MAX_LEDS : int'(chain_len_q);
   endfunction

   // queue one expected pulse symbol of the given kind
   function automatic void push_symbol(kind_type kind, bit is_last);
      rsp_type           sym;
      logic [1:0]        lv;
      logic [TICK_W-1:0] t1;
      logic [TICK_W-1:0] t2;
      case (kind)
         KIND_ZERO: begin
            lv = levels_q[1:0];
            t1 = zero_first_q;
            t2 = zero_second_q;
         end
         KIND_ONE: begin
            lv = levels_q[3:2];
            t1 = one_first_q;
            t2 = one_second_q;
         end
         default: begin
            lv = levels_q[5:4];
            t1 = latch_first_q;
            t2 = latch_second_q;
         end
      endcase
      sym.first_level  = lv[0];
      sym.first_ticks  = t1;
      sym.second_level = lv[1];
      sym.second_ticks = t2;
      sym.last         = is_last;
      symbol_queue.insert(symbol_queue.size(), sym);
   endfunction

   // update the shadow store and queue the symbols one accepted item causes
   function automatic void predict_symbols(req_type item);
      int       n;
      int       i;
      bit       tail;
      kind_type kind;
      n = leds_in_use();
      case (item.func)
         FUNC_WRITE: begin
            if (item.pixel_index < n) begin
               pixel_q[item.pixel_index]   = {item.green, item.red, item.blue};
               written_q[item.pixel_index] = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            for (i = 0; i < n; i++) begin
               pixel_q[i]   = '0;
               written_q[i] = 1'b1;
            end
         end
         FUNC_EMIT: begin
            if (item.pixel_index < n) begin
               tail = (item.pixel_index + 1 == n);
               for (i = 0; i < PIXEL_BITS; i++) begin
                  // a never-written pixel sends reset symbols only
                  if (!written_q[item.pixel_index])
                     kind = KIND_LATCH;
                  else if (pixel_q[item.pixel_index][PIXEL_BITS-1-i])
                     kind = KIND_ONE;
                  else
                     kind = KIND_ZERO;
                  push_symbol(kind, !tail && i == PIXEL_BITS - 1);
               end
               if (tail)
                  push_symbol(KIND_LATCH, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic req_type make_req(logic [1:0] func, logic [7:0] ix,
                                        logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_type item;
      item.func        = func;
      item.pixel_index = ix;
      item.red         = r;
      item.green       = g;
      item.blue        = b;
      return item;
   endfunction

   // offer one item, wait for its transfer, then maybe idle a while
   task automatic send_item(req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_symbols(item);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   // APB write: setup, then access, then idle before returning
   task automatic write_register(reg_index_type idx, logic [CSR_DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_CHAIN_LEN:    chain_len_q    = value[COUNT_W-1:0];
         REG_ZERO_FIRST:   zero_first_q   = value[TICK_W-1:0];
         REG_ZERO_SECOND:  zero_second_q  = value[TICK_W-1:0];
         REG_ONE_FIRST:    one_first_q    = value[TICK_W-1:0];
         REG_ONE_SECOND:   one_second_q   = value[TICK_W-1:0];
         REG_LATCH_FIRST:  latch_first_q  = value[TICK_W-1:0];
         REG_LATCH_SECOND: latch_second_q = value[TICK_W-1:0];
         default:          levels_q       = value[5:0];
      endcase
      @(posedge clock);
   endtask

   // wait for every expected symbol, then let a clear walk finish
   task automatic settle();
      req_valid <= 1'b0;
      while (symbol_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_chain(int count, int zf, int zs, int of, int os,
                                  int lf, int ls, int levels);
      settle();
      write_register(REG_CHAIN_LEN, count);
      write_register(REG_ZERO_FIRST, zf);
      write_register(REG_ZERO_SECOND, zs);
      write_register(REG_ONE_FIRST, of);
      write_register(REG_ONE_SECOND, os);
      write_register(REG_LATCH_FIRST, lf);
      write_register(REG_LATCH_SECOND, ls);
      write_register(REG_PHASE_LEVELS, levels);
   endtask

   task automatic configure_random(int count);
      configure_chain(count, $urandom_range(TICK_MAX), $urandom_range(TICK_MAX),
                      $urandom_range(TICK_MAX), $urandom_range(TICK_MAX),
                      $urandom_range(TICK_MAX), $urandom_range(TICK_MAX),
                      $urandom_range(63));
   endtask

   // random mix of effective items plus ignored ones; target counts effective items
   task automatic run_traffic(int target);
      int      done;
      int      n;
      int      pick;
      req_type item;
      done = 0;
      while (done < target) begin
         n    = leds_in_use();
         pick = $urandom_range(99);
         item = make_req(FUNC_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
         if (n > 0 && pick < 44) begin
            item.func        = FUNC_WRITE;
            item.pixel_index = 8'($urandom_range(n - 1));
            done++;
         end else if (n > 0 && pick < 86) begin
            item.func        = FUNC_EMIT;
            // bias toward the last LED so the trailing reset shows up often
            item.pixel_index = ($urandom_range(4) == 0) ? 8'(n - 1) : 8'($urandom_range(n - 1));
            done++;
         end else if (n > 0 && pick < 89) begin
            item.func = FUNC_CLEAR;
            done++;
         end else if (pick < 95 && n < MAX_LEDS) begin
            item.func        = $urandom_range(1) ? FUNC_WRITE : FUNC_EMIT;
            item.pixel_index = 8'($urandom_range(MAX_LEDS - 1, n));
         end
         send_item(item);
      end
   endtask

   task automatic set_idling(int mode);
      case (mode)
         1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
         3: begin sender_idle_pct = 7;  receiver_stall_pct = 7;  end
         default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      endcase
   endtask

   // symbol check and receiver stall
   always @(posedge clock) begin : check_symbols
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (symbol_queue.size() == 0) begin
            report_mismatch("unexpected symbol", rsp_data, '0);
         end else begin
            want = symbol_queue.pop_front();
            if (rsp_data.first_level !== want.first_level)
               report_mismatch("first_level", rsp_data.first_level, want.first_level);
            if (rsp_data.first_ticks !== want.first_ticks)
               report_mismatch("first_ticks", rsp_data.first_ticks, want.first_ticks);
            if (rsp_data.second_level !== want.second_level)
               report_mismatch("second_level", rsp_data.second_level, want.second_level);
            if (rsp_data.second_ticks !== want.second_ticks)
               report_mismatch("second_ticks", rsp_data.second_ticks, want.second_ticks);
            if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
      end
      // long hold-off once, otherwise random stalls
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request && !hold_served) begin
         hold_served = 1'b1;
         hold_left   = HOLD_CYCLES - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // chain length zero after reset: everything is ignored
   task automatic test_disabled_chain();
      send_item(make_req(FUNC_EMIT, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(FUNC_WRITE, 8'd5, 8'hff, 8'hff, 8'hff));
      send_item(make_req(FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(FUNC_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff));
   endtask

   // unwritten pixels, extreme colors, tail reset, indexes past the chain
   task automatic test_pixel_symbols();
      configure_chain(4, 0, TICK_MAX, TICK_MAX, 1, 15'h5555, 15'h2aaa, 6'b100110);
      send_item(make_req(FUNC_EMIT, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(FUNC_EMIT, 8'd3, 8'd0, 8'd0, 8'd0));
      send_item(make_req(FUNC_WRITE, 8'd0, 8'hff, 8'hff, 8'hff));
      send_item(make_req(FUNC_EMIT, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(FUNC_WRITE, 8'd1, 8'h00, 8'h00, 8'h00));
      send_item(make_req(FUNC_EMIT, 8'd1, 8'hff, 8'hff, 8'hff));
      send_item(make_req(FUNC_WRITE, 8'd2, 8'h5a, 8'ha5, 8'h3c));
      send_item(make_req(FUNC_EMIT, 8'd2, 8'd0, 8'd0, 8'd0));
      send_item(make_req(FUNC_WRITE, 8'd3, 8'h01, 8'h80, 8'hfe));
      send_item(make_req(FUNC_EMIT, 8'd3, 8'd0, 8'd0, 8'd0));
      send_item(make_req(FUNC_WRITE, 8'd4, 8'hff, 8'hff, 8'hff));
      send_item(make_req(FUNC_EMIT, 8'd4, 8'd0, 8'd0, 8'd0));
   endtask

   // clear blacks out the LEDs in use
   task automatic test_clear_all();
      send_item(make_req(FUNC_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff));
      send_item(make_req(FUNC_EMIT, 8'd2, 8'd0, 8'd0, 8'd0));
      send_item(make_req(FUNC_EMIT, 8'd3, 8'd0, 8'd0, 8'd0));
   endtask

   // longest chain: last index, a pixel the earlier clear did not reach
   task automatic test_full_chain();
      configure_chain(MAX_LEDS, TICK_MAX, 0, 0, TICK_MAX, TICK_MAX, TICK_MAX, 6'b011001);
      send_item(make_req(FUNC_WRITE, 8'd255, 8'h80, 8'h01, 8'haa));
      send_item(make_req(FUNC_EMIT, 8'd255, 8'd0, 8'd0, 8'd0));
      send_item(make_req(FUNC_EMIT, 8'd100, 8'd0, 8'd0, 8'd0));
      send_item(make_req(FUNC_EMIT, 8'd3, 8'd0, 8'd0, 8'd0));
   endtask

   // receiver holds off while emits keep coming, so the request side stalls
   task automatic test_input_backpressure();
      int i;
      configure_random(12);
      set_idling(0);
      for (i = 0; i < 4; i++)
         send_item(make_req(FUNC_WRITE, 8'(i * 3), 8'($urandom), 8'($urandom),
                            8'($urandom)));
      hold_request = 1'b1;
      for (i = 0; i < 30; i++)
         send_item(make_req(FUNC_EMIT, 8'($urandom_range(11)), 8'($urandom),
                            8'($urandom), 8'($urandom)));
   endtask

   // random phases over chain lengths, timings and idling patterns
   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure_chain(MAX_LEDS, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX,
                               TICK_MAX, TICK_MAX, 63);
            1: configure_chain(1, 0, 0, 0, 0, 0, 0, 0);
            default: configure_random(($urandom_range(2) == 0) ? MAX_LEDS
                                                              : $urandom_range(2, 40));
         endcase
         set_idling(phase % 4);
         run_traffic(25);
      end
      set_idling(0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_disabled_chain();
      test_pixel_symbols();
      test_clear_all();
      test_full_chain();
      test_input_backpressure();
      test_random_traffic();
      settle();
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rgbppe_pkg.sv
rtl/rgb_pixel_pulse_encoder_core.sv
tb/rgb_pixel_pulse_encoder_core_test.sv
